// ===== hdl/oale_pkg.sv =====
// Shared codes, widths and types for the ordered array list engine.
package oale_pkg;

  // Fixed field widths
  localparam int OP_W      = 3;
  localparam int POS_W     = 7;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 7;
  localparam int ST_W      = 2;

  // Default sizing
  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_WORD_BITS = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT_AT     = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT_SORTED = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_AT     = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_VALUE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_AT       = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR         = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

  // Shift command broadcast to every cell in the apply cycle
  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } oale_cmd_t;

endpackage

// ===== hdl/ordered_array_list_engine.sv =====
// A request accepted while idle passes through the compare, scan and apply states; the result strobe is
// registered from the apply state. A new request is taken only once the last one is done; busy covers the compare,
// scan and apply steps through the cell row and the scan network, and drops as the result is presented.
// Reset (synchronous, rst_n low) empties the list, idles the sequencer and drops out_valid;
// entry contents are not cleared. The result is a single-cycle strobe with no back-pressure.
// Top level: fixed-capacity array list held in a row of cells with a sequencer.
module ordered_array_list_engine #(
  parameter int CAPACITY  = oale_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = oale_pkg::DEF_WORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [oale_pkg::OP_W-1:0]      in_op,
  input  logic [oale_pkg::POS_W-1:0]     in_position,
  input  logic [oale_pkg::VAL_W-1:0]     in_value,
  output logic                           out_valid,
  output logic [oale_pkg::VAL_W-1:0]     out_read_value,
  output logic [oale_pkg::CNT_OUT_W-1:0] out_count,
  output logic [oale_pkg::ST_W-1:0]      out_status
);
  import oale_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [OP_W-1:0]      op_r;
  logic [POS_W-1:0]     pos_r;
  logic [WORD_BITS-1:0] word_r;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                 out_valid_r;
  logic [VAL_W-1:0]     out_read_value_r, out_read_value_nxt;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic [ST_W-1:0]      out_status_r, status_nxt;

  logic                 accept;
  logic                 do_ins;
  logic                 do_rem;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     cnt_ext;
  oale_cmd_t            cmd;

  logic [WORD_BITS-1:0] entry   [CAPACITY];
  logic [WORD_BITS-1:0] rd_word [CAPACITY];
  logic [CAPACITY-1:0]  le;
  logic [CAPACITY-1:0]  match;
  logic [CAPACITY-1:0]  ge;
  logic [CAPACITY-1:0]  eq;
  logic                 found;
  logic [WORD_BITS-1:0] scan_rd;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(count_r);

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      pos_r  <= in_position;
      word_r <= WORD_BITS'(in_value);
    end
  end

  // sequencer
  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_SCAN;
      S_SCAN:  state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // operation decode and status, evaluated in the apply cycle
  always_comb begin
    do_ins             = 1'b0;
    do_rem             = 1'b0;
    status_nxt         = ST_OK;
    out_read_value_nxt = '0;
    count_nxt          = count_r;
    case (op_r)
      OP_INSERT_AT: begin
        if (cnt_ext == CMP_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_INSERT_SORTED: begin
        if (cnt_ext == CMP_W'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_REMOVE_AT: begin
        if (pos_ext >= cnt_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          do_rem = 1'b1;
        end
      end
      OP_REMOVE_VALUE: begin
        if (found) begin
          do_rem = 1'b1;
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      OP_READ_AT: begin
        if (pos_ext >= cnt_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          out_read_value_nxt = VAL_W'(scan_rd);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    if (do_ins) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_rem) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  assign cmd.shift_up   = (state_r == S_APPLY) && do_ins;
  assign cmd.shift_down = (state_r == S_APPLY) && do_rem;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_APPLY);
      if (state_r == S_APPLY) begin
        count_r <= count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_APPLY) begin
      out_read_value_r <= out_read_value_nxt;
      out_count_r      <= CNT_OUT_W'(count_nxt);
      out_status_r     <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

  // row of cells; cell 0 takes the request word from below, the top cell holds on remove
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    if (j == 0) begin : g_lo
      assign left_w = word_r;
    end else begin : g_lo
      assign left_w = entry[j-1];
    end
    if (j == CAPACITY - 1) begin : g_hi
      assign right_w = entry[j];
    end else begin : g_hi
      assign right_w = entry[j+1];
    end

    oale_cell #(
      .WORD_BITS (WORD_BITS),
      .CMP_W     (CMP_W),
      .IDX       (j)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (cnt_ext),
      .pos         (pos_ext),
      .word        (word_r),
      .left_entry  (left_w),
      .right_entry (right_w),
      .ge          (ge[j]),
      .eq          (eq[j]),
      .entry_r     (entry[j]),
      .le_r        (le[j]),
      .match_r     (match[j]),
      .rd_r        (rd_word[j])
    );
  end

  // target slot and read data network
  oale_scan #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS),
    .CMP_W     (CMP_W)
  ) u_scan (
    .clk      (clk),
    .op       (op_r),
    .pos      (pos_ext),
    .le       (le),
    .match    (match),
    .rd_words (rd_word),
    .ge_r     (ge),
    .eq_r     (eq),
    .found_r  (found),
    .rd_r     (scan_rd)
  );

  // occupancy never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= CMP_W'(CAPACITY))
    else $error("count above capacity");

  // every accepted request yields its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("result strobe missing");

  // strobe follows the apply step only
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_APPLY)
    else $error("stray result strobe");

  // failed requests return zero data (non-read requests drive zero too)
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_read_value == '0)
    else $error("nonzero data on failed request");

  // count moves by at most one per request, or drops to zero on clear
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |=> (count_r == $past(count_r)) || (count_r == '0) ||
      (count_r == CNT_W'($past(count_r) + 1'b1)) ||
      (count_r == CNT_W'($past(count_r) - 1'b1)))
    else $error("count jumped");

endmodule

// ===== hdl/oale_cell.sv =====
// One list cell: holds one entry, compares it locally and shifts with its neighbors.
module oale_cell #(
  parameter int WORD_BITS = oale_pkg::DEF_WORD_BITS,
  parameter int CMP_W     = 8,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  oale_pkg::oale_cmd_t   cmd,
  input  logic [CMP_W-1:0]      count,
  input  logic [CMP_W-1:0]      pos,
  input  logic [WORD_BITS-1:0]  word,
  input  logic [WORD_BITS-1:0]  left_entry,
  input  logic [WORD_BITS-1:0]  right_entry,
  input  logic                  ge,
  input  logic                  eq,
  output logic [WORD_BITS-1:0]  entry_r,
  output logic                  le_r,
  output logic                  match_r,
  output logic [WORD_BITS-1:0]  rd_r
);
  import oale_pkg::*;

  logic                 in_use;
  logic                 le_nxt;
  logic                 match_nxt;
  logic [WORD_BITS-1:0] rd_nxt;
  logic [WORD_BITS-1:0] entry_nxt;

  // local compare against the request word and position
  always_comb begin
    in_use    = CMP_W'(IDX) < count;
    le_nxt    = in_use && (entry_r <= word);
    match_nxt = in_use && (entry_r == word);
    rd_nxt    = (CMP_W'(IDX) == pos) ? entry_r : '0;
  end

  // entry update: open a gap (insert) or close one (remove) at and above the target
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.shift_up && ge) begin
      entry_nxt = eq ? word : left_entry;
    end else if (cmd.shift_down && ge) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    le_r    <= le_nxt;
    match_r <= match_nxt;
    rd_r    <= rd_nxt;
  end

endmodule

// ===== hdl/oale_scan.sv =====
// Scan network over the cell flags: target slot, match found and read data.
module oale_scan #(
  parameter int CAPACITY  = oale_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = oale_pkg::DEF_WORD_BITS,
  parameter int CMP_W     = 8
) (
  input  logic                      clk,
  input  logic [oale_pkg::OP_W-1:0] op,
  input  logic [CMP_W-1:0]          pos,
  input  logic [CAPACITY-1:0]       le,
  input  logic [CAPACITY-1:0]       match,
  input  logic [WORD_BITS-1:0]      rd_words [CAPACITY],
  output logic [CAPACITY-1:0]       ge_r,
  output logic [CAPACITY-1:0]       eq_r,
  output logic                      found_r,
  output logic [WORD_BITS-1:0]      rd_r
);
  import oale_pkg::*;

  logic [CAPACITY-1:0]  pre_match;
  logic [CAPACITY-1:0]  suf_le;
  logic [CAPACITY-1:0]  ge_pos;
  logic [CAPACITY-1:0]  ge_nxt;
  logic [CAPACITY-1:0]  eq_nxt;
  logic [WORD_BITS-1:0] rd_nxt;

  // log-depth prefix OR of matches (upward) and suffix OR of le flags (downward)
  always_comb begin
    pre_match = match;
    suf_le    = le;
    for (int d = 1; d < CAPACITY; d = d * 2) begin
      pre_match = pre_match | (pre_match << d);
      suf_le    = suf_le | (suf_le >> d);
    end
  end

  // slots at or above the request position
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      ge_pos[j] = CMP_W'(j) >= pos;
    end
  end

  // pick the target boundary per operation; eq marks the lowest moved slot
  always_comb begin
    case (op)
      OP_INSERT_SORTED: ge_nxt = ~suf_le;
      OP_REMOVE_VALUE:  ge_nxt = pre_match;
      default:          ge_nxt = ge_pos;
    endcase
    eq_nxt = ge_nxt & ~(ge_nxt << 1);
  end

  // read data: only the addressed cell drives nonzero
  always_comb begin
    rd_nxt = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      rd_nxt = rd_nxt | rd_words[j];
    end
  end

  always_ff @(posedge clk) begin
    ge_r    <= ge_nxt;
    eq_r    <= eq_nxt;
    found_r <= |match;
    rd_r    <= rd_nxt;
  end

endmodule
